@@ rtl/tsrr_pkg.sv @@
// Shared types and constants for the round-robin task slot table.
`default_nettype none
package tsrr_pkg;

  localparam int SLOTS_DEFAULT = 8;
  localparam int CMD_W         = 3;
  localparam int IDX_W         = 3;
  localparam int PRIO_IN_W     = 32;
  localparam int STATUS_W      = 3;
  localparam int ID_W          = 31;
  localparam int PRIO_W        = 31;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC   = 3'd0,
    CMD_MKREADY = 3'd1,
    CMD_PICK    = 3'd2,
    CMD_YIELD   = 3'd3,
    CMD_EXIT    = 3'd4,
    CMD_SETPRIO = 3'd5
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK      = 3'd0,
    STS_NOFREE  = 3'd1,
    STS_NOREADY = 3'd2,
    STS_NOCUR   = 3'd3,
    STS_PRIREJ  = 3'd4,
    STS_WRONG   = 3'd5
  } status_t;

  typedef enum logic {
    FSM_IDLE = 1'b0,
    FSM_EXEC = 1'b1
  } fsm_t;

endpackage
`default_nettype wire

@@ rtl/tsrr_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module tsrr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

@@ rtl/task_slot_table_round_robin.sv @@
// Round-robin task slot table: slot state masks, id/priority RAMs, result register.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one command transaction: cmd,
//   slot_index (make ready only) and priority_code (set priority only).
//   Output channel (out_valid/out_ready) returns exactly one result
//   transaction per command: status, slot_out, task_id, priority_out.
//   A command accepted in idle reads the id and priority RAMs into their
//   registered outputs; the execute state then updates them and loads the
//   output register once it is empty or being drained. No new command is
//   taken until the execute state has finished.
//   Slot states live in three flop masks (free, ready, running); allocated
//   is the case where none is set. Id and priority live in RAMs; a free slot
//   reads id zero and a never-written priority reads zero via a valid mask.
//   Reset (rst, synchronous) frees every slot, sets the id counter to one,
//   clears the current task and the search start, and empties the output
//   register. No clearing pass is needed; in_ready rises right after reset.
//   When the receiver stalls, the result holds in the output register and a
//   following command is still taken; it then waits in its execute cycle
//   until the output register frees up.
`default_nettype none
module task_slot_table_round_robin #(
  parameter int SLOTS = tsrr_pkg::SLOTS_DEFAULT
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [tsrr_pkg::CMD_W-1:0]     cmd,
  input  wire logic [tsrr_pkg::IDX_W-1:0]     slot_index,
  input  wire logic [tsrr_pkg::PRIO_IN_W-1:0] priority_code,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [tsrr_pkg::STATUS_W-1:0]       status,
  output logic [tsrr_pkg::IDX_W-1:0]          slot_out,
  output logic [tsrr_pkg::ID_W-1:0]           task_id,
  output logic [tsrr_pkg::PRIO_W-1:0]         priority_out
);
  import tsrr_pkg::*;

  localparam int PW = $clog2(SLOTS);

  // Slot state masks; allocated = not free, not ready, not running.
  logic [SLOTS-1:0] free_mask, free_mask_next;
  logic [SLOTS-1:0] ready_mask, ready_mask_next;
  logic [SLOTS-1:0] run_mask, run_mask_next;
  logic [SLOTS-1:0] pri_vld, pri_vld_next;

  logic [ID_W-1:0]  id_counter, id_counter_next;
  logic [PW-1:0]    current_slot, current_slot_next;
  logic             current_valid, current_valid_next;
  logic [PW-1:0]    search_start, search_start_next;

  fsm_t fsm, fsm_next;

  // Command latched at accept
  cmd_t            cmd_q;
  status_t         status_q;
  logic            named_q;
  logic            have_cur_q;
  logic [PW-1:0]   tgt_q;
  logic            id_ok_q;
  logic            pri_ok_q;
  logic [PRIO_W-1:0] prio_q;

  // Accept-side decode
  logic            accept;
  logic            have_cur;
  logic [PW-1:0]   idx_p;
  logic            idx_bad;
  logic [SLOTS-1:0] pick_mask, pick_high;
  logic            free_any, pick_any, high_any;
  logic [PW-1:0]   free_sel, pick_sel, high_sel;
  logic            prio_good;
  status_t         status_d;
  logic            named_d;
  logic [PW-1:0]   tgt_d;

  // Execute-side
  logic            exec_done;
  logic            out_load;
  status_t         out_status_d;
  logic [IDX_W-1:0] out_slot_d;
  logic [ID_W-1:0] out_id_d;
  logic [PRIO_W-1:0] out_prio_d;
  logic [ID_W-1:0] id_rd;
  logic [PRIO_W-1:0] pri_rd;
  logic            id_we, pri_we;

  assign in_ready = (fsm == FSM_IDLE);
  assign accept   = in_valid && in_ready;
  assign have_cur = current_valid && run_mask[current_slot];
  assign idx_p    = PW'(slot_index);
  assign idx_bad  = (32'(slot_index) >= SLOTS);
  // signed priority_code >= 2: sign clear and some bit above bit 0 set
  assign prio_good = !priority_code[PRIO_IN_W-1] && (priority_code[PRIO_IN_W-2:1] != '0);

  // Pick considers the running task as already put back to ready.
  always_comb begin
    pick_mask = ready_mask;
    if (have_cur) begin
      pick_mask[current_slot] = 1'b1;
    end
    pick_high = pick_mask & ({SLOTS{1'b1}} << search_start);
  end

  // Lowest-set priority encoders
  always_comb begin
    free_any = 1'b0;
    pick_any = 1'b0;
    high_any = 1'b0;
    free_sel = '0;
    pick_sel = '0;
    high_sel = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (free_mask[i]) begin
        free_any = 1'b1;
        free_sel = PW'(i);
      end
      if (pick_mask[i]) begin
        pick_any = 1'b1;
        pick_sel = PW'(i);
      end
      if (pick_high[i]) begin
        high_any = 1'b1;
        high_sel = PW'(i);
      end
    end
  end

  // Status and target slot at accept
  always_comb begin
    status_d = STS_WRONG;
    named_d  = 1'b0;
    tgt_d    = '0;
    case (cmd)
      CMD_ALLOC: begin
        status_d = free_any ? STS_OK : STS_NOFREE;
        named_d  = free_any;
        tgt_d    = free_sel;
      end
      CMD_MKREADY: begin
        if (!idx_bad) begin
          named_d  = 1'b1;
          tgt_d    = idx_p;
          status_d = (!free_mask[idx_p] && !ready_mask[idx_p] && !run_mask[idx_p])
                     ? STS_OK : STS_WRONG;
        end
      end
      CMD_PICK: begin
        status_d = pick_any ? STS_OK : STS_NOREADY;
        named_d  = pick_any;
        tgt_d    = high_any ? high_sel : pick_sel;
      end
      CMD_YIELD, CMD_EXIT, CMD_SETPRIO: begin
        status_d = have_cur ? STS_OK : STS_NOCUR;
        named_d  = have_cur;
        tgt_d    = current_slot;
        if (have_cur && cmd == CMD_SETPRIO && !prio_good) begin
          status_d = STS_PRIREJ;
        end
      end
      default: begin
        status_d = STS_WRONG;
      end
    endcase
  end

  tsrr_ram #(.WIDTH(ID_W), .DEPTH(SLOTS)) u_id_ram (
    .clk   (clk),
    .we    (id_we),
    .waddr (tgt_q),
    .wdata (id_counter),
    .re    (accept),
    .raddr (tgt_d),
    .rdata (id_rd)
  );

  tsrr_ram #(.WIDTH(PRIO_W), .DEPTH(SLOTS)) u_pri_ram (
    .clk   (clk),
    .we    (pri_we),
    .waddr (tgt_q),
    .wdata (prio_q),
    .re    (accept),
    .raddr (tgt_d),
    .rdata (pri_rd)
  );

  // Execute: finish only when the output register can take the result.
  assign exec_done = (fsm == FSM_EXEC) && (!out_valid || out_ready);
  assign id_we     = exec_done && cmd_q == CMD_ALLOC && status_q == STS_OK;
  assign pri_we    = exec_done && cmd_q == CMD_SETPRIO && status_q == STS_OK;
  assign out_load  = exec_done;

  always_comb begin
    fsm_next           = fsm;
    free_mask_next     = free_mask;
    ready_mask_next    = ready_mask;
    run_mask_next      = run_mask;
    pri_vld_next       = pri_vld;
    id_counter_next    = id_counter;
    current_slot_next  = current_slot;
    current_valid_next = current_valid;
    search_start_next  = search_start;

    case (fsm)
      FSM_IDLE: begin
        if (accept) begin
          fsm_next = FSM_EXEC;
        end
      end
      FSM_EXEC: begin
        if (exec_done) begin
          fsm_next = FSM_IDLE;
          case (cmd_q)
            CMD_ALLOC: begin
              if (status_q == STS_OK) begin
                free_mask_next[tgt_q] = 1'b0;
                id_counter_next = (id_counter == {ID_W{1'b1}}) ? ID_W'(1)
                                                               : id_counter + ID_W'(1);
              end
            end
            CMD_MKREADY: begin
              if (status_q == STS_OK) begin
                ready_mask_next[tgt_q] = 1'b1;
              end
            end
            CMD_PICK: begin
              if (have_cur_q) begin
                run_mask_next[current_slot]   = 1'b0;
                ready_mask_next[current_slot] = 1'b1;
              end
              current_valid_next = 1'b0;
              if (status_q == STS_OK) begin
                ready_mask_next[tgt_q] = 1'b0;
                run_mask_next[tgt_q]   = 1'b1;
                current_slot_next      = tgt_q;
                current_valid_next     = 1'b1;
                search_start_next      = (tgt_q == PW'(SLOTS - 1)) ? '0 : tgt_q + PW'(1);
              end
            end
            CMD_YIELD: begin
              if (status_q == STS_OK) begin
                run_mask_next[tgt_q]   = 1'b0;
                ready_mask_next[tgt_q] = 1'b1;
                current_valid_next     = 1'b0;
              end
            end
            CMD_EXIT: begin
              // Free slot reads id zero; no RAM write needed.
              if (status_q == STS_OK) begin
                run_mask_next[tgt_q]  = 1'b0;
                free_mask_next[tgt_q] = 1'b1;
                current_valid_next    = 1'b0;
              end
            end
            CMD_SETPRIO: begin
              if (status_q == STS_OK) begin
                pri_vld_next[tgt_q] = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
        fsm_next = FSM_IDLE;
      end
    endcase
  end

  // Result fields
  always_comb begin
    out_status_d = status_q;
    out_slot_d   = '0;
    out_id_d     = '0;
    out_prio_d   = '0;
    if (named_q) begin
      out_slot_d = IDX_W'(tgt_q);
      if (cmd_q == CMD_ALLOC) begin
        out_id_d = id_counter;
      end else if (id_ok_q) begin
        out_id_d = id_rd;
      end
      if (cmd_q == CMD_SETPRIO && status_q == STS_OK) begin
        out_prio_d = prio_q;
      end else if (pri_ok_q) begin
        out_prio_d = pri_rd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fsm           <= FSM_IDLE;
      free_mask     <= '1;
      ready_mask    <= '0;
      run_mask      <= '0;
      pri_vld       <= '0;
      id_counter    <= ID_W'(1);
      current_slot  <= '0;
      current_valid <= 1'b0;
      search_start  <= '0;
      out_valid     <= 1'b0;
    end else begin
      fsm           <= fsm_next;
      free_mask     <= free_mask_next;
      ready_mask    <= ready_mask_next;
      run_mask      <= run_mask_next;
      pri_vld       <= pri_vld_next;
      id_counter    <= id_counter_next;
      current_slot  <= current_slot_next;
      current_valid <= current_valid_next;
      search_start  <= search_start_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q      <= cmd_t'(cmd);
      status_q   <= status_d;
      named_q    <= named_d;
      have_cur_q <= have_cur;
      tgt_q      <= tgt_d;
      id_ok_q    <= !free_mask[tgt_d];
      pri_ok_q   <= pri_vld[tgt_d];
      prio_q     <= priority_code[PRIO_W-1:0];
    end
    if (out_load) begin
      status       <= out_status_d;
      slot_out     <= out_slot_d;
      task_id      <= out_id_d;
      priority_out <= out_prio_d;
    end
  end

endmodule
`default_nettype wire

@@ rtl/tsrr_chk.sv @@
// Port-level checker for the task slot table, bound to the top level.
`default_nettype none
module tsrr_chk (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           in_valid,
  input wire logic                           in_ready,
  input wire logic                           out_valid,
  input wire logic                           out_ready,
  input wire logic [tsrr_pkg::STATUS_W-1:0]  status,
  input wire logic [tsrr_pkg::IDX_W-1:0]     slot_out,
  input wire logic [tsrr_pkg::ID_W-1:0]      task_id,
  input wire logic [tsrr_pkg::PRIO_W-1:0]    priority_out
);
  import tsrr_pkg::*;

  // Reset empties the result register.
  a_rst_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // One command in flight: no accept in the cycle after an accept.
  a_one_inflight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted back to back");

  // Result is loaded by the execute state that follows accept when the output was empty.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && !out_valid) |-> ##2 out_valid)
    else $error("result missing two cycles after accept");

  // Results with status no free, no ready or no current name no slot and carry zero fields.
  a_unnamed_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status == STS_NOFREE || status == STS_NOREADY || status == STS_NOCUR))
    |-> (slot_out == '0 && task_id == '0 && priority_out == '0))
    else $error("unnamed result with nonzero fields");

  // Stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(status) && $stable(slot_out)
                                   && $stable(task_id) && $stable(priority_out)))
    else $error("stalled result changed");

endmodule

bind task_slot_table_round_robin tsrr_chk u_tsrr_chk (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .status       (status),
  .slot_out     (slot_out),
  .task_id      (task_id),
  .priority_out (priority_out)
);
`default_nettype wire

@@ tb/task_slot_table_round_robin_test.sv @@
// Self-checking regression for the round-robin task slot table.
module task_slot_table_round_robin_test;
  import tsrr_pkg::*;

  localparam int SLOT_COUNT   = SLOTS_DEFAULT;
  localparam int RANDOM_ITEMS = 1500;
  localparam int PLAN_ROWS    = 23;
  // Commands past set priority are undefined; the block must refuse them.
  localparam logic [CMD_W-1:0] CMD_UNDEF_LO = 3'd6;
  localparam logic [CMD_W-1:0] CMD_UNDEF_HI = 3'd7;
  // Result register sits behind the input; allow a margin after draining.
  localparam int SETTLE_CYCLES = 12;
  localparam int MAX_REPORTS   = 10;

  // Slot lifecycle as the scoreboard tracks it.
  typedef enum logic [1:0] {
    SLOT_FREE  = 2'd0,
    SLOT_ALLOC = 2'd1,
    SLOT_READY = 2'd2,
    SLOT_RUN   = 2'd3
  } slot_state_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [IDX_W-1:0]    slot;
    logic [ID_W-1:0]     tid;
    logic [PRIO_W-1:0]   prio;
  } sched_result_t;

  // One directed row: command, repeat count, and an optional hand-typed result.
  typedef struct packed {
    logic [CMD_W-1:0]     c;
    logic [IDX_W-1:0]     idx;
    logic [PRIO_IN_W-1:0] pc;
    logic [3:0]           reps;
    bit                   typed;
    sched_result_t        want;
  } dir_row_t;

  localparam sched_result_t NO_WANT = '0;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_ready;
  logic [CMD_W-1:0]     cmd;
  logic [IDX_W-1:0]     slot_index;
  logic [PRIO_IN_W-1:0] priority_code;
  logic                 out_valid;
  logic                 out_ready;
  logic [STATUS_W-1:0]  status;
  logic [IDX_W-1:0]     slot_out;
  logic [ID_W-1:0]      task_id;
  logic [PRIO_W-1:0]    priority_out;

  task_slot_table_round_robin u_top (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .cmd           (cmd),
    .slot_index    (slot_index),
    .priority_code (priority_code),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .slot_out      (slot_out),
    .task_id       (task_id),
    .priority_out  (priority_out)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Scoreboard copy of the slot table
  // ---------------------------------------------------------------------------
  slot_state_t       slot_phase [SLOT_COUNT];
  logic [ID_W-1:0]   slot_tid   [SLOT_COUNT];
  logic [PRIO_W-1:0] slot_prio  [SLOT_COUNT];
  logic [ID_W-1:0]   next_tid;
  int                cur_slot;
  bit                cur_valid;
  int                scan_from;

  sched_result_t pending_results [$];
  int            fault_count;
  bit            send_burst;
  bit            take_burst;
  bit            fill_bias;

  function automatic bit task_running();
    return cur_valid && slot_phase[cur_slot] == SLOT_RUN;
  endfunction

  // Result fields are zero whenever the outcome names no slot.
  function automatic sched_result_t slot_report(logic [STATUS_W-1:0] st, int s, bit named);
    sched_result_t r;
    r = '0;
    r.status = st;
    if (named) begin
      r.slot = s[IDX_W-1:0];
      r.tid  = slot_tid[s];
      r.prio = slot_prio[s];
    end
    return r;
  endfunction

  // Applies one command to the scoreboard table and returns the result it owes.
  function automatic sched_result_t sched_outcome(logic [CMD_W-1:0] c, logic [IDX_W-1:0] idx,
                                                 logic [PRIO_IN_W-1:0] pc);
    int s;
    sched_result_t r;
    s = 0;
    case (c)
      CMD_ALLOC: begin
        // lowest free slot; its old priority survives
        for (int i = 0; i < SLOT_COUNT; i++) begin
          if (slot_phase[i] == SLOT_FREE) begin
            slot_phase[i] = SLOT_ALLOC;
            slot_tid[i]   = next_tid;
            next_tid      = (next_tid == {ID_W{1'b1}}) ? 31'd1 : next_tid + 31'd1;
            return slot_report(STS_OK, i, 1'b1);
          end
        end
        return slot_report(STS_NOFREE, 0, 1'b0);
      end
      CMD_MKREADY: begin
        if (slot_phase[idx] != SLOT_ALLOC) return slot_report(STS_WRONG, int'(idx), 1'b1);
        slot_phase[idx] = SLOT_READY;
        return slot_report(STS_OK, int'(idx), 1'b1);
      end
      CMD_PICK: begin
        // running task is preempted first, then the scan covers every slot
        if (task_running()) slot_phase[cur_slot] = SLOT_READY;
        cur_valid = 1'b0;
        for (int i = 0; i < SLOT_COUNT; i++) begin
          s = (scan_from + i) % SLOT_COUNT;
          if (slot_phase[s] == SLOT_READY) begin
            slot_phase[s] = SLOT_RUN;
            cur_slot      = s;
            cur_valid     = 1'b1;
            scan_from     = (s + 1) % SLOT_COUNT;
            return slot_report(STS_OK, s, 1'b1);
          end
        end
        return slot_report(STS_NOREADY, 0, 1'b0);
      end
      CMD_YIELD: begin
        if (!task_running()) return slot_report(STS_NOCUR, 0, 1'b0);
        slot_phase[cur_slot] = SLOT_READY;
        cur_valid = 1'b0;
        return slot_report(STS_OK, cur_slot, 1'b1);
      end
      CMD_EXIT: begin
        if (!task_running()) return slot_report(STS_NOCUR, 0, 1'b0);
        // report the leaving task before its id is wiped
        r = slot_report(STS_OK, cur_slot, 1'b1);
        slot_phase[cur_slot] = SLOT_FREE;
        slot_tid[cur_slot]   = '0;
        cur_valid = 1'b0;
        return r;
      end
      CMD_SETPRIO: begin
        if (!task_running()) return slot_report(STS_NOCUR, 0, 1'b0);
        // signed request must be at least two
        if (!pc[PRIO_IN_W-1] && pc >= 32'd2) begin
          slot_prio[cur_slot] = pc[PRIO_W-1:0];
          return slot_report(STS_OK, cur_slot, 1'b1);
        end
        return slot_report(STS_PRIREJ, cur_slot, 1'b1);
      end
      default: return slot_report(STS_WRONG, 0, 1'b0);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Directed plan. Hand-typed results only where obvious; the rest use the
  // scoreboard.
  // ---------------------------------------------------------------------------
  dir_row_t plan [PLAN_ROWS] = '{
    // empty table: every command that needs a task is refused
    '{CMD_PICK,     3'd0, 32'd0,        4'd1, 1'b1, '{STS_NOREADY, 3'd0, 31'd0, 31'd0}},
    '{CMD_YIELD,    3'd7, 32'hFFFFFFFF, 4'd1, 1'b1, '{STS_NOCUR,   3'd0, 31'd0, 31'd0}},
    '{CMD_SETPRIO,  3'd0, 32'd5,        4'd1, 1'b1, '{STS_NOCUR,   3'd0, 31'd0, 31'd0}},
    '{CMD_MKREADY,  3'd3, 32'd0,        4'd1, 1'b1, '{STS_WRONG,   3'd3, 31'd0, 31'd0}},
    '{CMD_UNDEF_LO, 3'd0, 32'd0,        4'd1, 1'b1, '{STS_WRONG,   3'd0, 31'd0, 31'd0}},
    // first ids come from a counter starting at one
    '{CMD_ALLOC,    3'd0, 32'd0,        4'd1, 1'b1, '{STS_OK,      3'd0, 31'd1, 31'd0}},
    '{CMD_ALLOC,    3'd0, 32'd0,        4'd1, 1'b1, '{STS_OK,      3'd1, 31'd2, 31'd0}},
    '{CMD_MKREADY,  3'd0, 32'd0,        4'd1, 1'b1, '{STS_OK,      3'd0, 31'd1, 31'd0}},
    // already ready, so not allocated
    '{CMD_MKREADY,  3'd0, 32'd0,        4'd1, 1'b1, '{STS_WRONG,   3'd0, 31'd1, 31'd0}},
    '{CMD_PICK,     3'd0, 32'd0,        4'd1, 1'b1, '{STS_OK,      3'd0, 31'd1, 31'd0}},
    // priority below two is refused, stored value reported
    '{CMD_SETPRIO,  3'd0, 32'd1,        4'd1, 1'b1, '{STS_PRIREJ,  3'd0, 31'd1, 31'd0}},
    '{CMD_SETPRIO,  3'd0, 32'h80000000, 4'd1, 1'b1, '{STS_PRIREJ,  3'd0, 31'd1, 31'd0}},
    '{CMD_SETPRIO,  3'd0, 32'd2,        4'd1, 1'b1, '{STS_OK,      3'd0, 31'd1, 31'd2}},
    '{CMD_SETPRIO,  3'd0, 32'h7FFFFFFF, 4'd1, 1'b1,
      '{STS_OK, 3'd0, 31'd1, 31'h7FFFFFFF}},
    '{CMD_YIELD,    3'd0, 32'd0,        4'd1, 1'b0, NO_WANT},
    '{CMD_MKREADY,  3'd1, 32'd0,        4'd1, 1'b0, NO_WANT},
    '{CMD_PICK,     3'd0, 32'd0,        4'd1, 1'b0, NO_WANT},
    // pick while running: preempt then rotate past the current slot
    '{CMD_PICK,     3'd0, 32'd0,        4'd1, 1'b0, NO_WANT},
    '{CMD_EXIT,     3'd0, 32'd0,        4'd1, 1'b0, NO_WANT},
    // refill every slot; the exited slot keeps its priority
    '{CMD_ALLOC,    3'd0, 32'd0,        4'd7, 1'b0, NO_WANT},
    '{CMD_ALLOC,    3'd0, 32'd0,        4'd1, 1'b1, '{STS_NOFREE,  3'd0, 31'd0, 31'd0}},
    '{CMD_PICK,     3'd0, 32'd0,        4'd1, 1'b0, NO_WANT},
    '{CMD_EXIT,     3'd0, 32'd0,        4'd1, 1'b0, NO_WANT}
  };

  // ---------------------------------------------------------------------------
  // Command driver: payload changes on the falling edge, acceptance is seen on
  // the rising edge. Called and returns on a falling edge.
  // ---------------------------------------------------------------------------
  task automatic send_cmd(logic [CMD_W-1:0] c, logic [IDX_W-1:0] idx, logic [PRIO_IN_W-1:0] pc,
                          bit typed, sched_result_t want);
    int gap;
    sched_result_t predicted;
    if ($urandom_range(0, 29) == 0) send_burst = ~send_burst;
    gap = send_burst ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd           = c;
    slot_index    = idx;
    priority_code = pc;
    in_valid      = 1'b1;
    do @(posedge clk); while (!in_ready);
    // transaction accepted: scoreboard always advances, typed rows override
    predicted = sched_outcome(c, idx, pc);
    pending_results.push_back(typed ? want : predicted);
    @(negedge clk);
  endtask

  // Random command: mostly sensible lifecycle traffic with some abuse mixed in.
  task automatic random_command(output logic [CMD_W-1:0] c, output logic [IDX_W-1:0] idx,
                                output logic [PRIO_IN_W-1:0] pc);
    int roll;
    int alloc_hi;
    int exit_hi;
    int ready_slots [$];
    roll     = $urandom_range(0, 99);
    alloc_hi = fill_bias ? 30 : 14;
    exit_hi  = fill_bias ? 82 : 78;
    idx      = IDX_W'($urandom_range(0, 7));
    pc       = $urandom;
    if (roll < alloc_hi) c = CMD_ALLOC;
    else if (roll < alloc_hi + 20) c = CMD_MKREADY;
    else if (roll < alloc_hi + 38) c = CMD_PICK;
    else if (roll < alloc_hi + 48) c = CMD_YIELD;
    else if (roll < exit_hi) c = CMD_EXIT;
    else if (roll < 97) c = CMD_SETPRIO;
    else c = $urandom_range(0, 1) ? CMD_UNDEF_LO : CMD_UNDEF_HI;

    if (c == CMD_MKREADY && $urandom_range(0, 3) != 0) begin
      // aim at an allocated slot so tasks actually reach the ready queue
      for (int i = 0; i < SLOT_COUNT; i++)
        if (slot_phase[i] == SLOT_ALLOC) ready_slots.push_back(i);
      if (ready_slots.size() > 0)
        idx = IDX_W'(ready_slots[$urandom_range(0, ready_slots.size() - 1)]);
    end

    if (c == CMD_SETPRIO) begin
      roll = $urandom_range(0, 99);
      if (roll < 60) begin
        pc = $urandom & 32'h7FFFFFFF;
        if (pc < 32'd2) pc = 32'd2;
      end else if (roll < 75) begin
        pc = $urandom_range(0, 3);
      end else if (roll < 90) begin
        pc = $urandom | 32'h80000000;
      end else begin
        case ($urandom_range(0, 3))
          0:       pc = 32'h7FFFFFFF;
          1:       pc = 32'h80000000;
          2:       pc = 32'hFFFFFFFF;
          default: pc = 32'd0;
        endcase
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    logic [CMD_W-1:0]     c;
    logic [IDX_W-1:0]     idx;
    logic [PRIO_IN_W-1:0] pc;

    rst           = 1'b1;
    in_valid      = 1'b0;
    cmd           = CMD_ALLOC;
    slot_index    = '0;
    priority_code = '0;
    fault_count   = 0;
    send_burst    = 1'b0;
    fill_bias     = 1'b0;

    for (int i = 0; i < SLOT_COUNT; i++) begin
      slot_phase[i] = SLOT_FREE;
      slot_tid[i]   = '0;
      slot_prio[i]  = '0;
    end
    next_tid  = 31'd1;
    cur_slot  = 0;
    cur_valid = 1'b0;
    scan_from = 0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int r = 0; r < PLAN_ROWS; r++)
      for (int k = 0; k < plan[r].reps; k++)
        send_cmd(plan[r].c, plan[r].idx, plan[r].pc, plan[r].typed, plan[r].want);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // swing between filling and draining the table
      if (n % 40 == 0) fill_bias = 1'($urandom_range(0, 1));
      if (n > 0 && n % 250 == 0) begin
        // hold off until the block has answered everything in flight
        in_valid = 1'b0;
        while (pending_results.size() != 0) @(negedge clk);
      end
      random_command(c, idx, pc);
      send_cmd(c, idx, pc, 1'b0, NO_WANT);
    end

    in_valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    // any stray result in this window is caught by the monitor
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (fault_count == 0 && pending_results.size() == 0) begin
      $display("task_slot_table_round_robin regression: pass");
    end else begin
      $display("task_slot_table_round_robin regression: fail");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Result side: random back-pressure and in-order comparison
  // ---------------------------------------------------------------------------
  initial begin
    sched_result_t got;
    sched_result_t want;
    int stall;

    out_ready  = 1'b0;
    take_burst = 1'b0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      if ($urandom_range(0, 29) == 0) take_burst = ~take_burst;
      stall = take_burst ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
      got = '{status, slot_out, task_id, priority_out};
      if (pending_results.size() == 0) begin
        fault_count++;
        if (fault_count <= MAX_REPORTS)
          $display("%0t: unexpected result transaction status=%0d slot=%0d id=%0d prio=%0d",
                   $time, got.status, got.slot, got.tid, got.prio);
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status || got.slot !== want.slot ||
            got.tid !== want.tid || got.prio !== want.prio) begin
          fault_count++;
          if (fault_count <= MAX_REPORTS) begin
            $display("%0t: result mismatch", $time);
            $display("  expected status=%0d slot=%0d id=%0d prio=%0d",
                     want.status, want.slot, want.tid, want.prio);
            $display("  actual   status=%0d slot=%0d id=%0d prio=%0d",
                     got.status, got.slot, got.tid, got.prio);
          end
        end
      end
      @(negedge clk);
    end
  end

  // Time limit allows far more than the worst case per transaction needs.
  initial begin
    #2000000;
    $display("task_slot_table_round_robin regression: fail");
    $finish;
  end

endmodule
